@@ rtl/sps_pkg.sv @@
// Shared types and constants for the sensor poll scheduler.
package sps_pkg;

  // Configuration register indexes (byte address 4*i)
  localparam logic [1:0] REG_ENABLED       = 2'd0;
  localparam logic [1:0] REG_POLL_INTERVAL = 2'd1;
  localparam logic [1:0] REG_CONV_WAIT     = 2'd2;
  localparam logic [1:0] REG_MAX_FAILURES  = 2'd3;

  localparam logic [15:0] POLL_INTERVAL_RST = 16'd1000;
  localparam logic [7:0]  CONV_WAIT_RST     = 8'd2;
  localparam logic [3:0]  MAX_FAILURES_RST  = 4'd3;

  // Raw word conversion: temp = (raw*16500 >> 16) - 4000, hum = raw*100 >> 16
  localparam logic [30:0]        TEMP_SCALE   = 31'd16500;
  localparam logic signed [15:0] TEMP_OFFSET  = 16'sd4000;
  localparam logic [22:0]        HUM_SCALE    = 23'd100;
  localparam logic signed [15:0] TEMP_INVALID = -16'sd32768;
  localparam logic [7:0]         HUM_INVALID  = 8'hFF;

  typedef struct packed {
    logic        enabled;
    logic [15:0] poll_interval_ms;
    logic [7:0]  conv_wait_ms;
    logic [3:0]  max_failures;
  } cfg_t;

endpackage

@@ rtl/sps_cfg.sv @@
// APB configuration register file for the sensor poll scheduler.
module sps_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output sps_pkg::cfg_t cfg
);
  import sps_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled          <= 1'b0;
      cfg.poll_interval_ms <= POLL_INTERVAL_RST;
      cfg.conv_wait_ms     <= CONV_WAIT_RST;
      cfg.max_failures     <= MAX_FAILURES_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ENABLED:       cfg.enabled          <= pwdata[0];
        REG_POLL_INTERVAL: cfg.poll_interval_ms <= pwdata[15:0];
        REG_CONV_WAIT:     cfg.conv_wait_ms     <= pwdata[7:0];
        REG_MAX_FAILURES:  cfg.max_failures     <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ENABLED:       prdata = {31'd0, cfg.enabled};
      REG_POLL_INTERVAL: prdata = {16'd0, cfg.poll_interval_ms};
      REG_CONV_WAIT:     prdata = {24'd0, cfg.conv_wait_ms};
      REG_MAX_FAILURES:  prdata = {28'd0, cfg.max_failures};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

@@ rtl/sps_core.sv @@
// Input register, per-call scheduling step and result register.
module sps_core (
  input  logic               clk,
  input  logic               rst,
  input  sps_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        now_ms,
  input  logic               start_ok,
  input  logic               read_ok,
  input  logic [15:0]        raw_temp,
  input  logic [15:0]        raw_humidity,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               start_issued,
  output logic               read_issued,
  output logic signed [15:0] temp_centi,
  output logic [7:0]         hum_percent,
  output logic               reading_valid,
  output logic [3:0]         failure_count,
  output logic               waiting_phase
);
  import sps_pkg::*;

  // input stage
  logic        q_valid;
  logic [31:0] q_now;
  logic        q_start_ok;
  logic        q_read_ok;
  logic [15:0] q_raw_temp;
  logic [15:0] q_raw_hum;

  // scheduler state
  logic               phase;
  logic [31:0]        poll_start_time;
  logic [31:0]        trigger_time;
  logic signed [15:0] cached_centi;
  logic [7:0]         cached_hum;
  logic               cache_valid;
  logic [3:0]         fail_counter;

  logic               phase_next;
  logic [31:0]        poll_start_time_next;
  logic [31:0]        trigger_time_next;
  logic signed [15:0] cached_centi_next;
  logic [7:0]         cached_hum_next;
  logic               cache_valid_next;
  logic [3:0]         fail_counter_next;
  logic               started;
  logic               read_done;

  logic               advance;
  logic               load;
  logic [31:0]        poll_elapsed;
  logic [31:0]        wait_elapsed;
  logic [3:0]         fail_inc;
  logic               fail_limit;
  logic [30:0]        temp_prod;
  logic [22:0]        hum_prod;
  logic signed [15:0] temp_conv;
  logic [7:0]         hum_conv;

  assign advance  = !out_valid || out_ready;
  assign load     = q_valid && advance;
  assign in_ready = !q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      q_now      <= now_ms;
      q_start_ok <= start_ok;
      q_read_ok  <= read_ok;
      q_raw_temp <= raw_temp;
      q_raw_hum  <= raw_humidity;
    end
  end

  assign poll_elapsed = q_now - poll_start_time;
  assign wait_elapsed = q_now - trigger_time;

  assign temp_prod = 31'(q_raw_temp) * TEMP_SCALE;
  assign hum_prod  = 23'(q_raw_hum) * HUM_SCALE;
  assign temp_conv = $signed({1'b0, temp_prod[30:16]}) - TEMP_OFFSET;
  assign hum_conv  = {1'b0, hum_prod[22:16]};

  // saturating failure count; the limit reached drops the cached reading
  assign fail_inc   = (fail_counter < cfg.max_failures) ? fail_counter + 4'd1 : fail_counter;
  assign fail_limit = fail_inc >= cfg.max_failures;

  always_comb begin
    phase_next           = phase;
    poll_start_time_next = poll_start_time;
    trigger_time_next    = trigger_time;
    cached_centi_next    = cached_centi;
    cached_hum_next      = cached_hum;
    cache_valid_next     = cache_valid;
    fail_counter_next    = fail_counter;
    started              = 1'b0;
    read_done            = 1'b0;

    if (cfg.enabled) begin
      if (!phase) begin
        if (poll_elapsed >= {16'd0, cfg.poll_interval_ms}) begin
          started = 1'b1;
          if (q_start_ok) begin
            trigger_time_next = q_now;
            phase_next        = 1'b1;
          end else begin
            fail_counter_next    = fail_inc;
            poll_start_time_next = q_now;
            if (fail_limit) begin
              cache_valid_next  = 1'b0;
              cached_centi_next = TEMP_INVALID;
              cached_hum_next   = HUM_INVALID;
            end
          end
        end
      end else if (wait_elapsed >= {24'd0, cfg.conv_wait_ms}) begin
        read_done = 1'b1;
        if (q_read_ok) begin
          cached_centi_next = temp_conv;
          cached_hum_next   = hum_conv;
          cache_valid_next  = 1'b1;
          fail_counter_next = 4'd0;
        end else begin
          fail_counter_next = fail_inc;
          if (fail_limit) begin
            cache_valid_next  = 1'b0;
            cached_centi_next = TEMP_INVALID;
            cached_hum_next   = HUM_INVALID;
          end
        end
        poll_start_time_next = q_now;
        phase_next           = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= 1'b0;
      poll_start_time <= 32'd0;
      trigger_time    <= 32'd0;
      cached_centi    <= TEMP_INVALID;
      cached_hum      <= HUM_INVALID;
      cache_valid     <= 1'b0;
      fail_counter    <= 4'd0;
    end else if (load) begin
      phase           <= phase_next;
      poll_start_time <= poll_start_time_next;
      trigger_time    <= trigger_time_next;
      cached_centi    <= cached_centi_next;
      cached_hum      <= cached_hum_next;
      cache_valid     <= cache_valid_next;
      fail_counter    <= fail_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      start_issued  <= started;
      read_issued   <= read_done;
      temp_centi    <= cache_valid_next ? cached_centi_next : TEMP_INVALID;
      hum_percent   <= cache_valid_next ? cached_hum_next : HUM_INVALID;
      reading_valid <= cache_valid_next;
      failure_count <= fail_counter_next;
      waiting_phase <= phase_next;
    end
  end

  a_one_transfer: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(start_issued && read_issued))
    else $error("trigger and read issued in the same call");

  a_invalid_marks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !reading_valid) |->
      (temp_centi == TEMP_INVALID && hum_percent == HUM_INVALID))
    else $error("invalid reading without marker values");

  a_phase_on_load: assert property (@(posedge clk) disable iff (rst)
    !load |=> $stable(phase))
    else $error("phase changed without a transaction");

  a_read_from_wait: assert property (@(posedge clk) disable iff (rst)
    (load && read_done) |=> !phase)
    else $error("read did not return to idle");

endmodule

@@ rtl/sensor_poll_scheduler_unit.sv @@
// Sensor poll scheduler: top level.
//
// Each input transaction is one scheduler call: the current millisecond time,
// the outcome of a trigger or read issued in that call and the raw sensor
// words. Each call yields exactly one output transaction with the issue flags,
// the cached reading, the failure count and the phase after the call.
// Both channels are valid/ready. The result is registered: an accepted call
// passes the input register, then the step logic into the result register.
// One call is accepted every cycle while the output is not stalled; scheduler
// state is updated with the result register load, so the next call sees it.
// When the receiver stalls the result is held and the input register still
// takes one more call; after that in_ready drops until the result is taken.
// The APB port (4-bit paddr, register i at byte 4*i) sets enable, poll
// interval, conversion wait and failure limit; write it only while idle.
// Synchronous reset clears both stages, returns to idle with an invalid
// cache, zero failure count and default register values.
module sensor_poll_scheduler_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        now_ms,
  input  logic               start_ok,
  input  logic               read_ok,
  input  logic [15:0]        raw_temp,
  input  logic [15:0]        raw_humidity,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               start_issued,
  output logic               read_issued,
  output logic signed [15:0] temp_centi,
  output logic [7:0]         hum_percent,
  output logic               reading_valid,
  output logic [3:0]         failure_count,
  output logic               waiting_phase
);
  import sps_pkg::*;

  cfg_t cfg;

  sps_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sps_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .now_ms        (now_ms),
    .start_ok      (start_ok),
    .read_ok       (read_ok),
    .raw_temp      (raw_temp),
    .raw_humidity  (raw_humidity),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .start_issued  (start_issued),
    .read_issued   (read_issued),
    .temp_centi    (temp_centi),
    .hum_percent   (hum_percent),
    .reading_valid (reading_valid),
    .failure_count (failure_count),
    .waiting_phase (waiting_phase)
  );

endmodule

@@ sim/sensor_poll_scheduler_unit_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the sensor poll scheduler: directed calls, random traffic, stalls.
module sensor_poll_scheduler_unit_tb;
  import sps_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD    = 240;

  typedef struct {
    logic [31:0] now;
    logic        sok;
    logic        rok;
    logic [15:0] rt;
    logic [15:0] rh;
  } poll_call_t;

  typedef struct {
    logic               start;
    logic               rd;
    logic signed [15:0] temp;
    logic [7:0]         hum;
    logic               valid;
    logic [3:0]         fails;
    logic               waiting;
  } poll_result_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_ready;
  logic [31:0] now_ms;
  logic start_ok, read_ok;
  logic [15:0] raw_temp, raw_humidity;
  logic out_valid;
  logic out_ready = 1'b0;
  logic start_issued, read_issued;
  logic signed [15:0] temp_centi;
  logic [7:0] hum_percent;
  logic reading_valid;
  logic [3:0] failure_count;
  logic waiting_phase;

  sensor_poll_scheduler_unit u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .now_ms(now_ms), .start_ok(start_ok), .read_ok(read_ok),
    .raw_temp(raw_temp), .raw_humidity(raw_humidity),
    .out_valid(out_valid), .out_ready(out_ready),
    .start_issued(start_issued), .read_issued(read_issued),
    .temp_centi(temp_centi), .hum_percent(hum_percent),
    .reading_valid(reading_valid), .failure_count(failure_count),
    .waiting_phase(waiting_phase)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Scheduler shadow state
  cfg_t               shadow_cfg;
  logic               sched_waiting;
  logic [31:0]        poll_start_ms;
  logic [31:0]        trig_stamp;
  logic signed [15:0] cached_centi;
  logic [7:0]         cached_hum;
  logic               cache_ok;
  logic [3:0]         fail_cnt;

  poll_result_t expected_q[$];
  poll_result_t head;

  int unsigned cycles;
  int unsigned mismatches;
  int unsigned n_calls, n_triggers, n_reads, n_failures, n_invalidations, n_writes;
  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned hold_left;
  logic        hold_request;
  logic [31:0] clock_ms;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("MISMATCH cycle %0d: %s got 0x%0h expected 0x%0h", cycles, what, got, want);
  endtask

  function automatic void count_poll_failure();
    n_failures++;
    if (fail_cnt < shadow_cfg.max_failures)
      fail_cnt++;
    if (fail_cnt >= shadow_cfg.max_failures) begin
      n_invalidations++;
      cache_ok     = 1'b0;
      cached_centi = TEMP_INVALID;
      cached_hum   = HUM_INVALID;
    end
  endfunction

  // Advance the shadow scheduler by one call and return the result it must produce
  function automatic poll_result_t advance_scheduler(input poll_call_t c);
    poll_result_t r;
    logic [31:0] prod_t, prod_h;
    r.start = 1'b0;
    r.rd    = 1'b0;
    if (shadow_cfg.enabled) begin
      if (!sched_waiting) begin
        if (c.now - poll_start_ms >= {16'd0, shadow_cfg.poll_interval_ms}) begin
          r.start = 1'b1;
          if (c.sok) begin
            trig_stamp    = c.now;
            sched_waiting = 1'b1;
          end else begin
            count_poll_failure();
            poll_start_ms = c.now;
          end
        end
      end else if (c.now - trig_stamp >= {24'd0, shadow_cfg.conv_wait_ms}) begin
        r.rd = 1'b1;
        if (c.rok) begin
          prod_t       = {16'd0, c.rt} * TEMP_SCALE;
          prod_h       = {16'd0, c.rh} * HUM_SCALE;
          cached_centi = prod_t[31:16] - TEMP_OFFSET;
          cached_hum   = prod_h[23:16];
          cache_ok     = 1'b1;
          fail_cnt     = '0;
        end else begin
          count_poll_failure();
        end
        poll_start_ms = c.now;
        sched_waiting = 1'b0;
      end
    end
    n_triggers += r.start;
    n_reads    += r.rd;
    r.temp    = cache_ok ? cached_centi : TEMP_INVALID;
    r.hum     = cache_ok ? cached_hum : HUM_INVALID;
    r.valid   = cache_ok;
    r.fails   = fail_cnt;
    r.waiting = sched_waiting;
    return r;
  endfunction

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {idx, 2'b00}; pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    n_writes++;
    case (idx)
      REG_ENABLED:       shadow_cfg.enabled          = value[0];
      REG_POLL_INTERVAL: shadow_cfg.poll_interval_ms = value[15:0];
      REG_CONV_WAIT:     shadow_cfg.conv_wait_ms     = value[7:0];
      REG_MAX_FAILURES:  shadow_cfg.max_failures     = value[3:0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic check_registers();
    logic [31:0] got, want, mask;
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      psel = 1'b1; pwrite = 1'b0; penable = 1'b0; paddr = 4'(i * 4);
      @(negedge clk);
      penable = 1'b1;
      @(posedge clk);
      got = prdata;
      case (2'(i))
        REG_ENABLED:       begin want = {31'd0, shadow_cfg.enabled};          mask = 32'h1;    end
        REG_POLL_INTERVAL: begin want = {16'd0, shadow_cfg.poll_interval_ms}; mask = 32'hFFFF; end
        REG_CONV_WAIT:     begin want = {24'd0, shadow_cfg.conv_wait_ms};     mask = 32'hFF;   end
        default:           begin want = {28'd0, shadow_cfg.max_failures};     mask = 32'hF;    end
      endcase
      if ((got & mask) !== want)
        report_mismatch($sformatf("register %0d readback", i), got, want);
      @(negedge clk);
      psel = 1'b0; penable = 1'b0;
    end
  endtask

  // Offer one call; returns at the falling edge after acceptance with valid still high
  task automatic send_call(input poll_call_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    now_ms = c.now; start_ok = c.sok; read_ok = c.rok;
    raw_temp = c.rt; raw_humidity = c.rh;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    n_calls++;
    expected_q.push_back(advance_scheduler(c));
    @(negedge clk);
  endtask

  task automatic issue(input logic [31:0] now, input logic sok, input logic rok,
                       input logic [15:0] rt, input logic [15:0] rh);
    poll_call_t c;
    c.now = now; c.sok = sok; c.rok = rok; c.rt = rt; c.rh = rh;
    clock_ms = now;
    send_call(c);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (expected_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Disabled block ignores calls; registers read back their reset values
  task automatic test_register_defaults();
    check_registers();
    apb_write(REG_ENABLED, 32'd0);
    issue(32'd5000, 1'b1, 1'b1, 16'($urandom), 16'($urandom));
    issue(32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
    drain_results();
  endtask

  // Full trigger/read cycles at both ends of the raw word range
  task automatic test_conversion_range();
    apb_write(REG_ENABLED, 32'd1);
    issue(32'd999, 1'b1, 1'b1, 16'($urandom), 16'($urandom));
    issue(32'd1000, 1'b1, 1'b0, 16'($urandom), 16'($urandom));
    issue(32'd1001, 1'b0, 1'b1, 16'($urandom), 16'($urandom));
    issue(32'd1002, 1'b0, 1'b1, 16'h0000, 16'h0000);
    issue(32'd2002, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF);
    issue(32'd2004, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
    drain_results();
  endtask

  // Trigger and read failures reach the limit and drop the cache
  task automatic test_failure_hold();
    issue(32'd3004, 1'b0, 1'b1, 16'($urandom), 16'($urandom));
    issue(32'd4004, 1'b1, 1'b1, 16'($urandom), 16'($urandom));
    issue(32'd4006, 1'b1, 1'b0, 16'($urandom), 16'($urandom));
    issue(32'd5006, 1'b0, 1'b0, 16'($urandom), 16'($urandom));
    issue(32'd6006, 1'b0, 1'b1, 16'($urandom), 16'($urandom));
    drain_results();
  endtask

  // Counter above a freshly lowered limit holds and the next failure invalidates
  task automatic test_lowered_limit();
    apb_write(REG_MAX_FAILURES, 32'd15);
    issue(32'd7006, 1'b1, 1'b0, 16'($urandom), 16'($urandom));
    issue(32'd7008, 1'b0, 1'b1, 16'h8000, 16'h8000);
    issue(32'd8008, 1'b0, 1'b1, 16'($urandom), 16'($urandom));
    issue(32'd9008, 1'b0, 1'b1, 16'($urandom), 16'($urandom));
    drain_results();
    apb_write(REG_MAX_FAILURES, 32'd1);
    issue(32'd10008, 1'b0, 1'b1, 16'($urandom), 16'($urandom));
    drain_results();
  endtask

  // Zero interval, wait and limit; disable while waiting; time wraparound
  task automatic test_zero_settings_and_wrap();
    apb_write(REG_POLL_INTERVAL, 32'd0);
    apb_write(REG_CONV_WAIT, 32'd0);
    apb_write(REG_MAX_FAILURES, 32'd0);
    issue(32'd10008, 1'b1, 1'b0, 16'($urandom), 16'($urandom));
    issue(32'd10008, 1'b0, 1'b1, 16'h5A5A, 16'hA5A5);
    issue(32'd10008, 1'b0, 1'b1, 16'($urandom), 16'($urandom));
    issue(32'd10008, 1'b1, 1'b1, 16'($urandom), 16'($urandom));
    drain_results();
    apb_write(REG_ENABLED, 32'd0);
    issue(32'd20000, 1'b1, 1'b1, 16'($urandom), 16'($urandom));
    drain_results();
    apb_write(REG_ENABLED, 32'd1);
    apb_write(REG_POLL_INTERVAL, 32'd16);
    apb_write(REG_CONV_WAIT, 32'd255);
    apb_write(REG_MAX_FAILURES, 32'd3);
    issue(32'd20001, 1'b0, 1'b0, 16'($urandom), 16'($urandom));
    issue(32'hFFFF_FFF0, 1'b0, 1'b1, 16'($urandom), 16'($urandom));
    issue(32'h0000_0005, 1'b1, 1'b1, 16'($urandom), 16'($urandom));
    issue(32'h0000_0103, 1'b1, 1'b1, 16'($urandom), 16'($urandom));
    issue(32'h0000_0104, 1'b1, 1'b1, 16'($urandom), 16'($urandom));
    drain_results();
    check_registers();
  endtask

  // Mostly well-formed time progressions sized to the settings, with random time jumps
  task automatic test_random_traffic(input int unsigned s_pct, input int unsigned r_pct,
                                     input int n_items, input logic [15:0] interval,
                                     input logic [7:0] conv, input logic [3:0] limit,
                                     input int unsigned fail_pct);
    poll_call_t c;
    int unsigned span;
    apb_write(REG_POLL_INTERVAL, {16'd0, interval});
    apb_write(REG_CONV_WAIT, {24'd0, conv});
    apb_write(REG_MAX_FAILURES, {28'd0, limit});
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    span = (interval > conv) ? interval : conv;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(99) < 5)
        clock_ms = $urandom;
      else
        clock_ms += $urandom_range(0, span + span / 2 + 2);
      c.now = clock_ms;
      c.sok = ($urandom_range(99) >= fail_pct);
      c.rok = ($urandom_range(99) >= fail_pct);
      c.rt  = 16'($urandom);
      c.rh  = 16'($urandom);
      send_call(c);
    end
    drain_results();
  endtask

  // Receiver holds off long enough to back up the input, then drains
  task automatic test_output_backpressure();
    poll_call_t c;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 1'b1;
    for (int i = 0; i < 40; i++) begin
      clock_ms += $urandom_range(0, 6);
      c.now = clock_ms;
      c.sok = ($urandom_range(99) >= 20);
      c.rok = ($urandom_range(99) >= 20);
      c.rt  = 16'($urandom);
      c.rh  = 16'($urandom);
      send_call(c);
    end
    drain_results();
  endtask

  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with no call pending", 32'd0, 32'd0);
      end else begin
        head = expected_q.pop_front();
        if (start_issued !== head.start)
          report_mismatch("start_issued", {31'd0, start_issued}, {31'd0, head.start});
        if (read_issued !== head.rd)
          report_mismatch("read_issued", {31'd0, read_issued}, {31'd0, head.rd});
        if (temp_centi !== head.temp)
          report_mismatch("temp_centi", {16'd0, temp_centi}, {16'd0, head.temp});
        if (hum_percent !== head.hum)
          report_mismatch("hum_percent", {24'd0, hum_percent}, {24'd0, head.hum});
        if (reading_valid !== head.valid)
          report_mismatch("reading_valid", {31'd0, reading_valid}, {31'd0, head.valid});
        if (failure_count !== head.fails)
          report_mismatch("failure_count", {28'd0, failure_count}, {28'd0, head.fails});
        if (waiting_phase !== head.waiting)
          report_mismatch("waiting_phase", {31'd0, waiting_phase}, {31'd0, head.waiting});
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, expected_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; now_ms = '0; start_ok = 1'b0; read_ok = 1'b0;
    raw_temp = '0; raw_humidity = '0;
    cycles = 0; mismatches = 0;
    n_calls = 0; n_triggers = 0; n_reads = 0; n_failures = 0;
    n_invalidations = 0; n_writes = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    hold_left = 0; hold_request = 1'b0; clock_ms = '0;
    shadow_cfg.enabled          = 1'b0;
    shadow_cfg.poll_interval_ms = POLL_INTERVAL_RST;
    shadow_cfg.conv_wait_ms     = CONV_WAIT_RST;
    shadow_cfg.max_failures     = MAX_FAILURES_RST;
    sched_waiting = 1'b0; poll_start_ms = '0; trig_stamp = '0;
    cached_centi = TEMP_INVALID; cached_hum = HUM_INVALID;
    cache_ok = 1'b0; fail_cnt = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_register_defaults();
    test_conversion_range();
    test_failure_hold();
    test_lowered_limit();
    test_zero_settings_and_wrap();
    test_random_traffic(30, 71, 250, 16'd10, 8'd3, 4'd3, 25);
    test_random_traffic(71, 30, 250, 16'd1, 8'd0, 4'd15, 45);
    test_random_traffic(0, 0, 250, 16'd65535, 8'd255, 4'd1, 15);
    test_output_backpressure();

    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    while (expected_q.size() != 0) begin
      report_mismatch("result never produced", 32'd0, 32'd0);
      void'(expected_q.pop_front());
    end

    $display("Covered %0d calls: %0d triggers, %0d reads, %0d failures counted,",
             n_calls, n_triggers, n_reads, n_failures);
    $display("%0d cache drops, %0d register writes, %0d mismatches in %0d cycles",
             n_invalidations, n_writes, mismatches, cycles);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
